>>> src/ecg_pkg.sv
package ecg_pkg;

  localparam int unsigned MAX_EXPERTS = 256;
  localparam int unsigned MAX_GROUPS  = 64;

  localparam int unsigned COUNT_W = 32;
  localparam int unsigned ROW_W   = 6;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned GRP_W   = 6;
  localparam int unsigned NG_W    = 7;
  localparam int unsigned EPG_W   = 9;
  localparam int unsigned PIG_W   = EPG_W;
  localparam int unsigned PROD_W  = NG_W + EPG_W;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = EPG_W;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_EXPERTS_PER_GROUP = CFG_IDX_W'(1);

  localparam logic [NG_W-1:0]  NG_RESET  = NG_W'(8);
  localparam logic [EPG_W-1:0] EPG_RESET = EPG_W'(32);

  localparam logic KIND_GROUP  = 1'b0;
  localparam logic KIND_COLUMN = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [ROW_W-1:0]   row;
    logic [IDX_W-1:0]   index;
    logic [COUNT_W-1:0] value;
    logic               last;
  } res_t;

endpackage

>>> src/ecg_in_if.sv
interface ecg_in_if
  import ecg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output count, input ready);
  modport sink   (input valid, input count, output ready);
endinterface

>>> src/ecg_out_if.sv
interface ecg_out_if
  import ecg_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ROW_W-1:0]   row;
  logic [IDX_W-1:0]   index;
  logic [COUNT_W-1:0] value;
  logic               last;

  modport source (output valid, output kind, output row, output index, output value,
                  output last, input ready);
  modport sink   (input valid, input kind, input row, input index, input value,
                  input last, output ready);
endinterface

>>> src/ecg_ram.sv
module ecg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/expert_count_group_and_column_sum.sv
// Streams a row-major token-count matrix, one 32-bit count per transfer, and
// returns per-row group sums (kind 0) and, during the last row, per-expert
// column totals (kind 1); when an item produces both, the group sum comes
// first and last marks the final result of each item. The group add happens
// as the count is taken, and the column read-modify-write goes through one
// port pair of the column RAM, read as the count is taken and written as the
// item leaves the input register. Results leave at one per cycle while the
// output is ready, through a two-entry result buffer: a count is taken every
// cycle while results drain, an item that yields both results can hold the
// input until the buffer has room, and a stalled output holds the input once the
// buffer cannot take the next item's results. Configuration writes must be
// made only while the block is idle; an accepted write restarts the matrix at
// row 0, expert 0, and a write is ignored when it would give zero rows, zero
// experts per group, more than 64 rows or more experts in total than
// MaxExperts.
module expert_count_group_and_column_sum
  import ecg_pkg::*;
#(
  parameter int unsigned MaxExperts = MAX_EXPERTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ecg_in_if.sink                in_i,
  ecg_out_if.source             out_o
);

  localparam int unsigned EW = $clog2(MaxExperts);
  localparam int unsigned TW = $clog2(MaxExperts + 1);

  // configuration
  logic [NG_W-1:0]   ng_q, ng_new;
  logic [EPG_W-1:0]  epg_q, epg_new;
  logic [TW-1:0]     total_q;
  logic [PROD_W-1:0] prod;
  logic              cfg_hit, cfg_ok;

  always_comb begin
    ng_new  = ng_q;
    epg_new = epg_q;
    cfg_hit = 1'b0;
    unique case (cfg_idx_i)
      CFG_NUM_GROUPS: begin
        ng_new  = cfg_data_i[NG_W-1:0];
        cfg_hit = cfg_we_i;
      end
      CFG_EXPERTS_PER_GROUP: begin
        epg_new = cfg_data_i;
        cfg_hit = cfg_we_i;
      end
      default: cfg_hit = 1'b0;
    endcase
  end

  assign prod   = PROD_W'(ng_new) * PROD_W'(epg_new);
  assign cfg_ok = cfg_hit && (ng_new != '0) && (ng_new <= NG_W'(MAX_GROUPS))
                  && (epg_new != '0) && (prod <= PROD_W'(MaxExperts));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ng_q    <= NG_RESET;
      epg_q   <= EPG_RESET;
      total_q <= TW'(NG_RESET * EPG_RESET);
    end else if (cfg_ok) begin
      ng_q    <= ng_new;
      epg_q   <= epg_new;
      total_q <= prod[TW-1:0];
    end
  end

  // position counters and group accumulator, updated on each input transfer
  logic                in_fire;
  logic [COUNT_W-1:0]  acc_q, acc_d, gsum;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [EW-1:0]       e_q, e_d;
  logic [PIG_W-1:0]    pig_q, pig_d;
  logic [GRP_W-1:0]    grp_q, grp_d;
  logic                grp_emit, col_emit, end_row;

  assign in_fire  = in_i.valid && in_i.ready;
  assign gsum     = acc_q + in_i.count;
  assign grp_emit = (EPG_W'(pig_q) + EPG_W'(1)) >= epg_q;
  assign col_emit = (NG_W'(row_q) + NG_W'(1)) >= ng_q;
  assign end_row  = (TW'(e_q) + TW'(1)) >= total_q;

  always_comb begin
    acc_d = grp_emit ? '0 : gsum;
    pig_d = grp_emit ? '0 : pig_q + PIG_W'(1);
    grp_d = grp_emit ? grp_q + GRP_W'(1) : grp_q;
    e_d   = e_q + EW'(1);
    row_d = row_q;
    if (end_row) begin
      acc_d = '0;
      pig_d = '0;
      grp_d = '0;
      e_d   = '0;
      row_d = col_emit ? '0 : row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      row_q <= '0;
      e_q   <= '0;
      pig_q <= '0;
      grp_q <= '0;
    end else if (cfg_ok) begin
      acc_q <= '0;
      row_q <= '0;
      e_q   <= '0;
      pig_q <= '0;
      grp_q <= '0;
    end else if (in_fire) begin
      acc_q <= acc_d;
      row_q <= row_d;
      e_q   <= e_d;
      pig_q <= pig_d;
      grp_q <= grp_d;
    end
  end

  // input register
  logic               s1_valid_q;
  logic [COUNT_W-1:0] s1_count_q, s1_gsum_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [EW-1:0]      s1_e_q;
  logic [GRP_W-1:0]   s1_grp_q;
  logic               s1_gemit_q, s1_cemit_q, s1_first_q;
  logic               s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_count_q <= in_i.count;
      s1_gsum_q  <= gsum;
      s1_row_q   <= row_q;
      s1_e_q     <= e_q;
      s1_grp_q   <= grp_q;
      s1_gemit_q <= grp_emit;
      s1_cemit_q <= col_emit;
      s1_first_q <= (row_q == '0);
    end
  end

  // column totals
  logic [COUNT_W-1:0] col_rdata, col_sum;

  ecg_ram #(
    .Width (COUNT_W),
    .Depth (MaxExperts)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_e_q),
    .wdata_i (col_sum),
    .re_i    (in_fire),
    .raddr_i (e_q),
    .rdata_o (col_rdata)
  );

  assign col_sum = s1_first_q ? s1_count_q : col_rdata + s1_count_q;

  // results of the item in the input register
  res_t res_grp, res_col, push0, push1;
  logic [1:0] push_n;

  always_comb begin
    push_n = {1'b0, s1_gemit_q} + {1'b0, s1_cemit_q};

    res_grp.kind  = KIND_GROUP;
    res_grp.row   = s1_row_q;
    res_grp.index = IDX_W'(s1_grp_q);
    res_grp.value = s1_gsum_q;
    res_grp.last  = !s1_cemit_q;

    res_col.kind  = KIND_COLUMN;
    res_col.row   = s1_row_q;
    res_col.index = IDX_W'(s1_e_q);
    res_col.value = col_sum;
    res_col.last  = 1'b1;

    push0 = s1_gemit_q ? res_grp : res_col;
    push1 = res_col;
  end

  // two-entry result buffer
  res_t       buf0_q, buf1_q;
  logic [1:0] cnt_q;
  logic       out_fire;

  assign out_fire = out_o.valid && out_o.ready;
  assign s1_adv   = s1_valid_q && ((push_n == 2'd0) || (cnt_q == 2'd0)
                    || ((cnt_q == 2'd1) && out_o.ready));
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (s1_adv && (push_n != 2'd0)) begin
      cnt_q <= push_n;
    end else if (out_fire) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && (push_n != 2'd0)) begin
      buf0_q <= push0;
      buf1_q <= push1;
    end else if (out_fire) begin
      buf0_q <= buf1_q;
    end
  end

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.kind  = buf0_q.kind;
  assign out_o.row   = buf0_q.row;
  assign out_o.index = buf0_q.index;
  assign out_o.value = buf0_q.value;
  assign out_o.last  = buf0_q.last;

`ifndef ASSERT_OFF
  a_pig_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    EPG_W'(pig_q) < epg_q)
    else $error("position in group out of range");

  a_expert_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    TW'(e_q) < total_q)
    else $error("expert position out of range");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_gemit_q && s1_cemit_q |=>
      out_o.valid && !out_o.last && (out_o.kind == KIND_GROUP))
    else $error("group sum must lead a result pair");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && !out_o.last |=> out_o.valid && (out_o.kind == KIND_COLUMN))
    else $error("column total must follow a non-last group sum");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ecg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_3 = CFG_IDX_W'(3);

  localparam int unsigned RANDOM_ITEMS   = 750;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned REPORT_LIMIT   = 10;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ecg_in_if  in_if ();
  ecg_out_if out_if ();

  expert_count_group_and_column_sum dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  wire in_xfer  = in_if.valid && in_if.ready;
  wire out_xfer = out_if.valid && out_if.ready;

  logic [COUNT_W-1:0] counts_to_send [$];
  res_t               sums_due [$];
  int unsigned        mismatches = 0;
  logic               in_fire = 1'b0;

  // shadow of the block
  logic [NG_W-1:0]    shadow_groups = NG_RESET;
  logic [EPG_W-1:0]   shadow_epg    = EPG_RESET;
  logic [COUNT_W-1:0] column_sum [MAX_EXPERTS];
  logic [COUNT_W-1:0] group_sum     = '0;
  int unsigned        cur_row       = 0;
  int unsigned        cur_expert    = 0;
  int unsigned        cur_in_group  = 0;
  int unsigned        cur_group     = 0;

  function automatic void restart_matrix();
    group_sum    = '0;
    cur_row      = 0;
    cur_expert   = 0;
    cur_in_group = 0;
    cur_group    = 0;
  endfunction

  function automatic void apply_register_write(logic [CFG_IDX_W-1:0] idx,
                                               logic [CFG_DATA_W-1:0] data);
    int unsigned ng;
    int unsigned epg;
    ng  = shadow_groups;
    epg = shadow_epg;
    if (idx == CFG_NUM_GROUPS) begin
      ng = data[NG_W-1:0];
    end else if (idx == CFG_EXPERTS_PER_GROUP) begin
      epg = data[EPG_W-1:0];
    end else begin
      return;
    end
    if (ng == 0 || ng > MAX_GROUPS || epg == 0 || ng * epg > MAX_EXPERTS) begin
      return;
    end
    shadow_groups = NG_W'(ng);
    shadow_epg    = EPG_W'(epg);
    restart_matrix();
  endfunction

  function automatic void accumulate_count(logic [COUNT_W-1:0] cnt);
    int unsigned        total;
    int unsigned        e;
    logic [COUNT_W-1:0] col;
    res_t               grp_res;
    res_t               col_res;
    logic               has_grp;
    logic               has_col;
    total   = shadow_groups * shadow_epg;
    e       = cur_expert;
    has_grp = 1'b0;
    has_col = 1'b0;
    if (e >= MAX_EXPERTS) begin
      e = 0;
    end
    group_sum = group_sum + cnt;
    col = (cur_row == 0) ? cnt : column_sum[e] + cnt;
    column_sum[e] = col;
    if (cur_in_group + 1 >= shadow_epg) begin
      has_grp       = 1'b1;
      grp_res.kind  = KIND_GROUP;
      grp_res.row   = ROW_W'(cur_row);
      grp_res.index = IDX_W'(cur_group);
      grp_res.value = group_sum;
      grp_res.last  = 1'b0;
      group_sum     = '0;
      cur_in_group  = 0;
      cur_group++;
    end else begin
      cur_in_group++;
    end
    if (cur_row + 1 >= shadow_groups) begin
      has_col       = 1'b1;
      col_res.kind  = KIND_COLUMN;
      col_res.row   = ROW_W'(cur_row);
      col_res.index = IDX_W'(e);
      col_res.value = col;
      col_res.last  = 1'b1;
    end
    if (has_grp) begin
      grp_res.last = !has_col;
      sums_due.push_back(grp_res);
    end
    if (has_col) begin
      sums_due.push_back(col_res);
    end
    e++;
    if (e >= total) begin
      e            = 0;
      cur_group    = 0;
      cur_in_group = 0;
      group_sum    = '0;
      cur_row++;
      if (cur_row >= shadow_groups) begin
        cur_row = 0;
      end
    end
    cur_expert = e;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // sender: bursts of transfers with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (counts_to_send.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.count <= counts_to_send.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(48, 1);
          gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
        end else begin
          burst_left--;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int unsigned rx_cycle = 0;

  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case (rx_cycle[8:7])
      2'd0: begin
        out_if.ready <= 1'b1;
      end
      2'd1: begin
        out_if.ready <= ($urandom_range(1, 0) == 1);
      end
      2'd2: begin
        out_if.ready <= (rx_cycle[2:0] == 3'd0);
      end
      default: begin
        out_if.ready <= (rx_cycle[4:3] != 2'd3) && ($urandom_range(3, 0) != 0);
      end
    endcase
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    in_fire <= in_xfer;
    if (rst_ni) begin
      if (cfg_we_i) begin
        apply_register_write(cfg_idx_i, cfg_data_i);
      end
      if (in_xfer) begin
        accumulate_count(in_if.count);
      end
      if (out_xfer) begin
        got.kind  = out_if.kind;
        got.row   = out_if.row;
        got.index = out_if.index;
        got.value = out_if.value;
        got.last  = out_if.last;
        if (sums_due.size() == 0) begin
          if (mismatches < REPORT_LIMIT) begin
            $display("unexpected result: kind=%0d row=%0d index=%0d value=%h last=%0d",
                     got.kind, got.row, got.index, got.value, got.last);
          end
          mismatches++;
        end else begin
          want = sums_due.pop_front();
          if (got.kind !== want.kind || got.row !== want.row || got.index !== want.index ||
              got.value !== want.value || got.last !== want.last) begin
            if (mismatches < REPORT_LIMIT) begin
              $display("result differs: expected kind=%0d row=%0d index=%0d value=%h last=%0d",
                       want.kind, want.row, want.index, want.value, want.last);
              $display("                got      kind=%0d row=%0d index=%0d value=%h last=%0d",
                       got.kind, got.row, got.index, got.value, got.last);
            end
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned idle_run;
    idle_run = 0;
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (in_xfer || out_xfer ||
          (counts_to_send.size() == 0 && !in_if.valid && sums_due.size() == 0)) begin
        idle_run = 0;
      end else begin
        idle_run++;
      end
    end
    $display("expert_count_group_and_column_sum: mismatch");
    $finish;
  end

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      2: return {1'b1, (COUNT_W - 1)'($urandom)};
      3: return COUNT_W'($urandom_range(255, 0));
      default: return COUNT_W'($urandom);
    endcase
  endfunction

  task automatic wait_quiet();
    while (counts_to_send.size() != 0 || in_if.valid || sums_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // shrink the row count first so every step of the move is a legal shape
  task automatic select_shape(int unsigned ng, int unsigned epg);
    write_reg(CFG_NUM_GROUPS, CFG_DATA_W'(1));
    write_reg(CFG_EXPERTS_PER_GROUP, CFG_DATA_W'(epg));
    write_reg(CFG_NUM_GROUPS, CFG_DATA_W'(ng));
  endtask

  initial begin
    logic [COUNT_W-1:0] corner_counts [8];
    int unsigned random_sent;
    int unsigned ng;
    int unsigned epg;
    int unsigned matrix_len;
    int unsigned n_items;
    int unsigned noise;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.count  = '0;
    out_if.ready = 1'b0;
    foreach (column_sum[i]) column_sum[i] = '0;
    corner_counts = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h1,
                      32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000};
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset shape, left in the middle of a group
    counts_to_send.push_back(32'hFFFF_FFFF);
    counts_to_send.push_back(32'h0);
    counts_to_send.push_back(32'h1);
    counts_to_send.push_back(32'h8000_0000);
    counts_to_send.push_back(32'h7FFF_FFFF);
    wait_quiet();

    // refused writes and unmapped indexes
    write_reg(CFG_NUM_GROUPS, CFG_DATA_W'(0));
    write_reg(CFG_NUM_GROUPS, CFG_DATA_W'(65));
    write_reg(CFG_NUM_GROUPS, CFG_DATA_W'(9'h1C8));
    write_reg(CFG_NUM_GROUPS, CFG_DATA_W'(9'h109));
    write_reg(CFG_EXPERTS_PER_GROUP, CFG_DATA_W'(0));
    write_reg(CFG_EXPERTS_PER_GROUP, CFG_DATA_W'(257));
    write_reg(CFG_EXPERTS_PER_GROUP, CFG_DATA_W'(33));
    write_reg(CFG_NO_REG_2, CFG_DATA_W'(1));
    write_reg(CFG_NO_REG_3, CFG_DATA_W'(1));
    // upper bits of the row count are dropped
    write_reg(CFG_NUM_GROUPS, CFG_DATA_W'(9'h181));
    write_reg(CFG_EXPERTS_PER_GROUP, CFG_DATA_W'(2));
    write_reg(CFG_NUM_GROUPS, CFG_DATA_W'(2));
    foreach (corner_counts[i]) counts_to_send.push_back(corner_counts[i]);
    wait_quiet();

    select_shape(1, 1);
    counts_to_send.push_back(32'hFFFF_FFFF);
    counts_to_send.push_back(32'h0);
    counts_to_send.push_back(32'h1234_5678);
    wait_quiet();

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(9, 0))
        0, 1, 2, 3, 4, 5: begin
          ng  = $urandom_range(4, 1);
          epg = $urandom_range(8, 1);
        end
        6, 7: begin
          ng  = $urandom_range(16, 1);
          epg = $urandom_range(MAX_EXPERTS / ng, 1);
        end
        default: begin
          case ($urandom_range(3, 0))
            0: begin ng = MAX_GROUPS; epg = 1; end
            1: begin ng = MAX_GROUPS; epg = MAX_EXPERTS / MAX_GROUPS; end
            2: begin ng = 1; epg = MAX_EXPERTS; end
            default: begin ng = 16; epg = 16; end
          endcase
        end
      endcase
      noise = ($urandom_range(2, 0) == 0) ? $urandom_range(3, 1) : 0;
      repeat (noise) begin
        write_reg(CFG_IDX_W'($urandom_range(3, 0)), CFG_DATA_W'($urandom_range(511, 0)));
      end
      select_shape(ng, epg);
      matrix_len = ng * ng * epg;
      if (matrix_len <= 200) begin
        n_items = matrix_len * $urandom_range(2, 1) + $urandom_range(ng * epg, 0);
      end else begin
        n_items = $urandom_range(200, 60);
      end
      if (n_items > RANDOM_ITEMS - random_sent) begin
        n_items = RANDOM_ITEMS - random_sent;
      end
      repeat (n_items) counts_to_send.push_back(pick_count());
      random_sent += n_items;
      wait_quiet();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches += sums_due.size();
    if (mismatches == 0) begin
      $display("expert_count_group_and_column_sum: match");
    end else begin
      $display("expert_count_group_and_column_sum: mismatch");
    end
    $finish;
  end

endmodule
